>>> hw/rtl/pmu_rvc_pkg.sv
// Package for the regulator voltage control block: command and status codes,
// regulator descriptors and the voltage table of the table-mapped regulator.
// Depends on nothing; used by hw/rtl/pmu_regulator_voltage_control_top.sv.
package pmu_rvc_pkg;

	localparam int REG_COUNT      = 256;
	localparam int ADDR_W         = $clog2(REG_COUNT);
	localparam int TABLE_VOLTAGES = 16;
	localparam int TAB_IDX_W      = $clog2(TABLE_VOLTAGES);

	// Command codes carried by the func field.
	typedef enum logic [2:0] {
		FN_SET     = 3'd0,
		FN_GET     = 3'd1,
		FN_ENABLE  = 3'd2,
		FN_DISABLE = 3'd3,
		FN_STATUS  = 3'd4,
		FN_RAW_WR  = 3'd5,
		FN_RAW_RD  = 3'd6,
		FN_NONE    = 3'd7
	} func_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_NOREG = 2'd1,
		ST_RANGE = 2'd2,
		ST_TABLE = 2'd3
	} status_t;

	// Regulator indices.
	localparam logic [2:0] RAIL_DC2   = 3'd0;
	localparam logic [2:0] RAIL_DC3   = 3'd1;
	localparam logic [2:0] RAIL_LDO2  = 3'd2;
	localparam logic [2:0] RAIL_LDO3  = 3'd3;
	localparam logic [2:0] RAIL_LDO4  = 3'd4;
	localparam logic [2:0] RAIL_GPIO0 = 3'd5;

	// The gpio0 regulator uses a three-bit mode field; this mode means on.
	localparam logic [7:0] GPIO0_MODE_MASK = 8'h07;
	localparam logic [7:0] GPIO0_MODE_ON   = 8'h03;

	// Voltage step of a regulator.
	typedef enum logic [1:0] {
		STEP_25,
		STEP_100,
		STEP_TABLE
	} step_t;

	// Reciprocals for the division of the voltage offset by the step,
	// scaled by 2**RECIP_SHIFT. Exact for offsets up to 2800 mV.
	localparam int          RECIP_SHIFT = 17;
	localparam logic [12:0] RECIP_25    = 13'd5243;
	localparam logic [12:0] RECIP_100   = 13'd1311;

	typedef struct packed {
		logic [7:0]  vreg;
		logic [7:0]  ereg;
		logic [2:0]  ebit;
		logic [7:0]  fmask;
		logic [2:0]  fshift;
		logic [11:0] vmin;
		logic [11:0] vmax;
		step_t       step;
	} rail_t;

	// Descriptor of each regulator; unknown indices give an all-zero entry.
	function automatic rail_t rail_desc(input logic [2:0] ri);
		rail_t r;
		r = '0;
		unique case (ri)
			RAIL_DC2:   r = '{8'h23, 8'h12, 3'd4, 8'h3f, 3'd0, 12'd700,  12'd2275, STEP_25};
			RAIL_DC3:   r = '{8'h27, 8'h12, 3'd1, 8'h7f, 3'd0, 12'd700,  12'd3500, STEP_25};
			RAIL_LDO2:  r = '{8'h28, 8'h12, 3'd2, 8'hf0, 3'd4, 12'd1800, 12'd3300, STEP_100};
			RAIL_LDO3:  r = '{8'h29, 8'h12, 3'd6, 8'h7f, 3'd0, 12'd700,  12'd2275, STEP_25};
			RAIL_LDO4:  r = '{8'h28, 8'h12, 3'd3, 8'h0f, 3'd0, 12'd1250, 12'd3300, STEP_TABLE};
			RAIL_GPIO0: r = '{8'h91, 8'h90, 3'd2, 8'hf0, 3'd4, 12'd1800, 12'd3300, STEP_100};
			default:    r = '0;
		endcase
		return r;
	endfunction

	// Voltage table of the table-mapped regulator, in millivolts.
	function automatic logic [11:0] vtab(input logic [TAB_IDX_W-1:0] idx);
		logic [11:0] v;
		v = '0;
		unique case (idx)
			4'd0:  v = 12'd1250;
			4'd1:  v = 12'd1300;
			4'd2:  v = 12'd1400;
			4'd3:  v = 12'd1500;
			4'd4:  v = 12'd1600;
			4'd5:  v = 12'd1700;
			4'd6:  v = 12'd1800;
			4'd7:  v = 12'd1900;
			4'd8:  v = 12'd2000;
			4'd9:  v = 12'd2500;
			4'd10: v = 12'd2700;
			4'd11: v = 12'd2800;
			4'd12: v = 12'd3000;
			4'd13: v = 12'd3100;
			4'd14: v = 12'd3200;
			4'd15: v = 12'd3300;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

>>> hw/rtl/pmu_regulator_voltage_control_top.sv
// Regulator voltage control: a 256-byte register store served one command per item.
// Depends on hw/rtl/pmu_rvc_pkg.sv for codes, regulator descriptors and the voltage table.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  cmd     | in        | cmd_valid, cmd_stall | func, regulator, millivolts, reg_addr,
//          |           |                      | write_data
//  res     | out       | res_valid, res_stall | status, value
//
// Each item is read from the register store at the edge that accepts it; in the execute
// state the modified byte is written back and the result registered in the output register.
// The store is used as a single port: read on acceptance, written back in the execute state.
// Reset clears a valid bit per register at once; a register never written reads as zero.
// A stalled result holds in the output register; a new item is taken once it is free.
module pmu_regulator_voltage_control_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [2:0]  func,
	input  logic [2:0]  regulator,
	input  logic [15:0] millivolts,
	input  logic [7:0]  reg_addr,
	input  logic [7:0]  write_data,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [1:0]  status,
	output logic [11:0] value
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;

	logic        cmd_accept;

	// Decode of the incoming item.
	pmu_rvc_pkg::func_t   func_c;
	pmu_rvc_pkg::rail_t   rail_c;
	pmu_rvc_pkg::status_t status_c;
	logic                 is_reg_cmd_c;
	logic                 in_range_c;
	logic [11:0]          diff_c;
	logic [12:0]          recip_c;
	logic [24:0]          quot_prod_c;
	logic                 tab_hit_c;
	logic [pmu_rvc_pkg::TAB_IDX_W-1:0] tab_idx_c;
	logic [7:0]           code_c;
	logic [pmu_rvc_pkg::ADDR_W-1:0] raddr_c;

	// Stage one: the item as decoded, plus the store read.
	pmu_rvc_pkg::func_t   func_s1;
	pmu_rvc_pkg::status_t status_s1;
	pmu_rvc_pkg::step_t   step_s1;
	logic                 gpio_s1;
	logic [2:0]           ebit_s1;
	logic [7:0]           fmask_s1;
	logic [2:0]           fshift_s1;
	logic [11:0]          vmin_s1;
	logic [7:0]           code_s1;
	logic [pmu_rvc_pkg::ADDR_W-1:0] addr_s1;
	logic [7:0]           data_s1;
	logic [7:0]           mem_rdata_s1;
	logic                 rvalid_s1;

	// Register store and its valid bits.
	logic [7:0]                       mem [pmu_rvc_pkg::REG_COUNT];
	logic [pmu_rvc_pkg::REG_COUNT-1:0] valid_q;

	// Execution of the item.
	logic [7:0]  cur_c;
	logic [7:0]  field_c;
	logic [7:0]  ebit_mask_c;
	logic [6:0]  step_mult_c;
	logic [14:0] get_prod_c;
	logic [11:0] get_mv_c;
	logic [7:0]  wdata_c;
	logic        mem_we;
	logic [11:0] val_c;

	logic        res_valid_q;
	logic [1:0]  status_q;
	logic [11:0] value_q;

	// Handshake: one item in flight, and the output register must be free.
	assign cmd_stall  = (state_q != S_IDLE) || (res_valid_q && res_stall);
	assign cmd_accept = cmd_valid && !cmd_stall;

	// Decode the command, check the voltage and form the field code.
	always_comb begin
		func_c       = pmu_rvc_pkg::func_t'(func);
		rail_c       = pmu_rvc_pkg::rail_desc(regulator);
		is_reg_cmd_c = (func <= 3'd4);
		in_range_c   = (millivolts >= {4'b0, rail_c.vmin}) &&
		               (millivolts <= {4'b0, rail_c.vmax});
		diff_c       = millivolts[11:0] - rail_c.vmin;
		recip_c      = (rail_c.step == pmu_rvc_pkg::STEP_100) ?
		               pmu_rvc_pkg::RECIP_100 : pmu_rvc_pkg::RECIP_25;
		quot_prod_c  = 25'(diff_c) * 25'(recip_c);

		tab_hit_c = 1'b0;
		tab_idx_c = '0;
		for (int i = 0; i < pmu_rvc_pkg::TABLE_VOLTAGES; i++) begin
			if (!tab_hit_c &&
			    ({4'b0, pmu_rvc_pkg::vtab(pmu_rvc_pkg::TAB_IDX_W'(i))} == millivolts)) begin
				tab_hit_c = 1'b1;
				tab_idx_c = pmu_rvc_pkg::TAB_IDX_W'(i);
			end
		end

		if (rail_c.step == pmu_rvc_pkg::STEP_TABLE) begin
			code_c = 8'(tab_idx_c);
		end else begin
			code_c = quot_prod_c[pmu_rvc_pkg::RECIP_SHIFT +: 8];
		end

		status_c = pmu_rvc_pkg::ST_OK;
		if (is_reg_cmd_c && (regulator > pmu_rvc_pkg::RAIL_GPIO0)) begin
			status_c = pmu_rvc_pkg::ST_NOREG;
		end else if (func_c == pmu_rvc_pkg::FN_SET) begin
			if (!in_range_c) begin
				status_c = pmu_rvc_pkg::ST_RANGE;
			end else if (rail_c.step == pmu_rvc_pkg::STEP_TABLE && !tab_hit_c) begin
				status_c = pmu_rvc_pkg::ST_TABLE;
			end
		end

		unique case (func_c) inside
			pmu_rvc_pkg::FN_SET, pmu_rvc_pkg::FN_GET: raddr_c = rail_c.vreg;
			pmu_rvc_pkg::FN_ENABLE, pmu_rvc_pkg::FN_DISABLE,
			pmu_rvc_pkg::FN_STATUS:                   raddr_c = rail_c.ereg;
			default:                                  raddr_c = reg_addr;
		endcase
	end

	// Stage one registers, loaded when an item is accepted.
	always_ff @(posedge clk) begin
		if (cmd_accept) begin
			func_s1   <= func_c;
			status_s1 <= status_c;
			step_s1   <= rail_c.step;
			gpio_s1   <= (regulator == pmu_rvc_pkg::RAIL_GPIO0);
			ebit_s1   <= rail_c.ebit;
			fmask_s1  <= rail_c.fmask;
			fshift_s1 <= rail_c.fshift;
			vmin_s1   <= rail_c.vmin;
			code_s1   <= code_c;
			addr_s1   <= raddr_c;
			data_s1   <= write_data;
		end
	end

	// Register store: read at acceptance, written back in the execute cycle.
	always_ff @(posedge clk) begin
		if (cmd_accept) begin
			mem_rdata_s1 <= mem[raddr_c];
		end
		if (mem_we) begin
			mem[addr_s1] <= wdata_c;
		end
	end

	// Valid bits: a register reads as zero until it is first written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			if (cmd_accept) begin
				rvalid_s1 <= valid_q[raddr_c];
			end
			if (mem_we) begin
				valid_q[addr_s1] <= 1'b1;
			end
		end
	end

	// Modify the byte read and form the result value.
	always_comb begin
		cur_c       = rvalid_s1 ? mem_rdata_s1 : 8'h00;
		field_c     = (cur_c & fmask_s1) >> fshift_s1;
		ebit_mask_c = 8'h01 << ebit_s1;
		step_mult_c = (step_s1 == pmu_rvc_pkg::STEP_100) ? 7'd100 : 7'd25;
		get_prod_c  = 15'(field_c) * 15'(step_mult_c);
		get_mv_c    = 12'(13'(vmin_s1) + 13'(get_prod_c));
		wdata_c     = cur_c;
		mem_we      = 1'b0;
		val_c       = '0;

		unique case (func_s1)
			pmu_rvc_pkg::FN_SET: begin
				wdata_c = (cur_c & ~fmask_s1) | 8'(code_s1 << fshift_s1);
				mem_we  = 1'b1;
			end
			pmu_rvc_pkg::FN_GET: begin
				if (step_s1 == pmu_rvc_pkg::STEP_TABLE) begin
					val_c = pmu_rvc_pkg::vtab(field_c[pmu_rvc_pkg::TAB_IDX_W-1:0]);
				end else begin
					val_c = get_mv_c;
				end
			end
			pmu_rvc_pkg::FN_ENABLE: begin
				wdata_c = gpio_s1 ?
				          ((cur_c & ~pmu_rvc_pkg::GPIO0_MODE_MASK) | pmu_rvc_pkg::GPIO0_MODE_ON) :
				          (cur_c | ebit_mask_c);
				mem_we  = 1'b1;
			end
			pmu_rvc_pkg::FN_DISABLE: begin
				wdata_c = gpio_s1 ? (cur_c | pmu_rvc_pkg::GPIO0_MODE_MASK) :
				                    (cur_c & ~ebit_mask_c);
				mem_we  = 1'b1;
			end
			pmu_rvc_pkg::FN_STATUS: begin
				if (gpio_s1) begin
					val_c = 12'((cur_c & pmu_rvc_pkg::GPIO0_MODE_MASK) ==
					            pmu_rvc_pkg::GPIO0_MODE_ON);
				end else begin
					val_c = 12'(cur_c[ebit_s1]);
				end
			end
			pmu_rvc_pkg::FN_RAW_WR: begin
				wdata_c = data_s1;
				mem_we  = 1'b1;
			end
			pmu_rvc_pkg::FN_RAW_RD: begin
				val_c = 12'(cur_c);
			end
			default: begin
				val_c = '0;
			end
		endcase

		// Errors change nothing and report a zero value.
		if (status_s1 != pmu_rvc_pkg::ST_OK) begin
			mem_we = 1'b0;
			val_c  = '0;
		end
		if (state_q != S_EXEC) begin
			mem_we = 1'b0;
		end
	end

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			status_q    <= '0;
			value_q     <= '0;
		end else begin
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_valid_q <= 1'b1;
					status_q    <= status_s1;
					value_q     <= val_c;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign status    = status_q;
	assign value     = value_q;

	// An accepted item is executed in the following cycle.
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_accept |=> (state_q == S_EXEC))
		else $error("accepted item was not executed in the next cycle");

	// The output register is free whenever an item executes.
	a_exec_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |-> !res_valid_q)
		else $error("result register occupied during execution");

	// Execution always yields a result in the next cycle.
	a_exec_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |=> res_valid_q)
		else $error("execution produced no result");

	// A written register is marked valid.
	a_write_valid: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> valid_q[$past(addr_s1)])
		else $error("written register not marked valid");

	// An error result carries a zero value.
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (status_q != pmu_rvc_pkg::ST_OK)) |-> (value_q == '0))
		else $error("error result with non-zero value");

endmodule
